// ===== hdl/cotp_pkg.sv =====
`timescale 1ns / 1ps

package cotp_pkg;

    localparam int ANGLE_BITS    = 16;
    localparam int CORDIC_STAGES = 18;
    localparam int CORDIC_CELLS  = (CORDIC_STAGES < 30) ? CORDIC_STAGES : 30;
    localparam int SQRT1_CELLS   = 30;
    localparam int SQRT2_CELLS   = 18;
    localparam int OUT_DEPTH_W   = 8;

    localparam logic [31:0] PHASE_MASK = ~((32'd1 << (32 - ANGLE_BITS)) - 32'd1);
    localparam logic signed [33:0] CORDIC_GAIN  = 34'sd652032874;
    localparam logic signed [33:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [33:0] HALF_TURN    = 34'sd2147483648;

    typedef enum logic [1:0] {
        REG_MAJOR_RADIUS = 2'd0,
        REG_OVAL_A       = 2'd1,
        REG_OVAL_B       = 2'd2,
        REG_NONE         = 2'd3
    } reg_index_t;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } rot_t;

    typedef struct packed {
        rot_t r;
        logic flip;
    } lane_t;

    // One rotator per angle: u, v and 2v
    typedef struct packed {
        lane_t u;
        lane_t v;
        lane_t w;
    } cord_t;

    typedef struct packed {
        logic signed [31:0] cu;
        logic signed [31:0] su;
        logic signed [31:0] cv;
        logic signed [31:0] sv;
        logic signed [31:0] c2v;
        logic signed [33:0] c;
        logic [57:0]        csq;
        logic [59:0]        rad;
        logic [29:0]        root;
        logic [33:0]        rem;
        logic               ok;
        logic signed [19:0] rsv;
        logic signed [19:0] rcv;
        logic signed [20:0] w;
        logic signed [22:0] px;
        logic signed [22:0] pz;
        logic [18:0]        x;
        logic [18:0]        y;
        logic [18:0]        z;
    } pt_t;

    // atan(2^-i) in units of 2^-32 turn
    function automatic logic [31:0] atan_turn(input logic [4:0] idx);
        logic [31:0] t;
        case (idx)
            5'd0:    t = 32'h20000000;
            5'd1:    t = 32'h12E4051E;
            5'd2:    t = 32'h09FB385B;
            5'd3:    t = 32'h051111D4;
            5'd4:    t = 32'h028B0D43;
            5'd5:    t = 32'h0145D7E1;
            5'd6:    t = 32'h00A2F61E;
            5'd7:    t = 32'h00517C55;
            5'd8:    t = 32'h0028BE53;
            5'd9:    t = 32'h00145F2F;
            5'd10:   t = 32'h000A2F98;
            5'd11:   t = 32'h000517CC;
            5'd12:   t = 32'h00028BE6;
            5'd13:   t = 32'h000145F3;
            5'd14:   t = 32'h0000A2FA;
            5'd15:   t = 32'h0000517D;
            5'd16:   t = 32'h000028BE;
            5'd17:   t = 32'h0000145F;
            5'd18:   t = 32'h00000A30;
            5'd19:   t = 32'h00000518;
            5'd20:   t = 32'h0000028C;
            5'd21:   t = 32'h00000146;
            5'd22:   t = 32'h000000A3;
            5'd23:   t = 32'h00000051;
            5'd24:   t = 32'h00000029;
            5'd25:   t = 32'h00000014;
            5'd26:   t = 32'h0000000A;
            5'd27:   t = 32'h00000005;
            5'd28:   t = 32'h00000003;
            5'd29:   t = 32'h00000001;
            default: t = 32'h00000000;
        endcase
        return t;
    endfunction

endpackage

// ===== hdl/cotp_cordic_cell.sv =====
`timescale 1ns / 1ps

module cotp_cordic_cell
    import cotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [4:0]  stage,
    input  logic        in_valid,
    output logic        in_ready,
    input  cord_t       in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output cord_t       out_data
);

    logic  valid_reg;
    cord_t data_reg;
    cord_t data_next;

    function automatic lane_t rotate(input lane_t l, input logic [4:0] sh);
        lane_t              o;
        logic signed [33:0] dx;
        logic signed [33:0] dy;
        logic signed [33:0] at;
        dx = l.r.y >>> sh;
        dy = l.r.x >>> sh;
        at = $signed({2'b00, atan_turn(sh)});
        o  = l;
        if (!l.r.z[33])
        begin
            o.r.x = l.r.x - dx;
            o.r.y = l.r.y + dy;
            o.r.z = l.r.z - at;
        end
        else
        begin
            o.r.x = l.r.x + dx;
            o.r.y = l.r.y - dy;
            o.r.z = l.r.z + at;
        end
        return o;
    endfunction

    always_comb
    begin
        data_next.u = rotate(in_data.u, stage);
        data_next.v = rotate(in_data.v, stage);
        data_next.w = rotate(in_data.w, stage);
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    // Hold the payload while stalled
    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== hdl/cotp_sqrt_cell.sv =====
`timescale 1ns / 1ps

module cotp_sqrt_cell
    import cotp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  pt_t  in_data,
    output logic out_valid,
    input  logic out_ready,
    output pt_t  out_data
);

    logic        valid_reg;
    pt_t         data_reg;
    pt_t         data_next;
    logic [33:0] rem_sh;
    logic [33:0] trial;

    // One root bit: bring down the next radicand pair, try subtracting 4*root+1
    always_comb
    begin
        rem_sh    = {in_data.rem[31:0], in_data.rad[59:58]};
        trial     = {2'b00, in_data.root, 2'b01};
        data_next = in_data;
        data_next.rad = {in_data.rad[57:0], 2'b00};
        if (rem_sh >= trial)
        begin
            data_next.rem  = rem_sh - trial;
            data_next.root = {in_data.root[28:0], 1'b1};
        end
        else
        begin
            data_next.rem  = rem_sh;
            data_next.root = {in_data.root[28:0], 1'b0};
        end
    end

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (in_ready)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            data_reg <= data_next;
    end

endmodule

// ===== hdl/cassini_oval_torus_point.sv =====
`timescale 1ns / 1ps
// Channel   Direction  Signals                        Item contents (low bit up)
// s_axis    in         tvalid tready tdata[31:0]      angle_u[15:0] angle_v[31:16]
// m_axis    out        tvalid tready tdata[63:0] tuser coord_x coord_y coord_z; point_valid
// cfg       in         valid ready index[1:0] data    0 major_radius, 1 oval_a, 2 oval_b
//
// One item enters per cycle and one point leaves per cycle while m_axis_tready
// holds high. An item passes the CORDIC cell row, the front stages, the two
// bit-per-cell square-root rows with the mid stage between them, and the back stages.
// Every stage holds its own valid bit, so an empty stage fills while the
// output waits; a stall only backs up as far as the first empty stage.
// Reset clears the valid bits and loads 1.0 into all three registers.

module cassini_oval_torus_point
    import cotp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // angle_u[15:0], angle_v[31:16]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata,   // coord_x[18:0], coord_y[37:19], coord_z[56:38], zero
    output logic        m_axis_tuser,   // point_valid[0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers and derived constants
    // ------------------------------------------------------------------
    logic [15:0]        major_radius_reg;
    logic [15:0]        oval_a_reg;
    logic [15:0]        oval_b_reg;
    logic [31:0]        a2_reg;
    logic [31:0]        b2_reg;
    logic [63:0]        a4_reg;
    logic [63:0]        b4_reg;
    logic signed [57:0] base_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            major_radius_reg <= 16'd4096;
            oval_a_reg       <= 16'd4096;
            oval_b_reg       <= 16'd4096;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (reg_index_t'(cfg_index))
                REG_MAJOR_RADIUS: major_radius_reg <= cfg_data;
                REG_OVAL_A:       oval_a_reg       <= cfg_data;
                REG_OVAL_B:       oval_b_reg       <= cfg_data;
                default:          ;     // drop writes past the last register
            endcase
        end
    end

    // Registered a2/b2, then a4/b4, then base; settles well before an item reaches its first use
    always_ff @(posedge clk)
    begin
        a2_reg   <= 32'(oval_a_reg) * 32'(oval_a_reg);
        b2_reg   <= 32'(oval_b_reg) * 32'(oval_b_reg);
        a4_reg   <= 64'(a2_reg) * 64'(a2_reg);
        b4_reg   <= 64'(b2_reg) * 64'(b2_reg);
        base_reg <= $signed({2'b00, b4_reg[63:8]}) - $signed({2'b00, a4_reg[63:8]});
    end

    // ------------------------------------------------------------------
    // Phase fold and CORDIC cell row (u, v and 2v side by side)
    // ------------------------------------------------------------------
    function automatic lane_t fold(input logic [31:0] ph);
        lane_t              l;
        logic signed [33:0] z;
        z      = 34'($signed(ph));
        l.flip = 1'b0;
        if (z > QUARTER_TURN)
        begin
            z      = z - HALF_TURN;
            l.flip = 1'b1;
        end
        else if (z < -QUARTER_TURN)
        begin
            z      = z + HALF_TURN;
            l.flip = 1'b1;
        end
        l.r.x = CORDIC_GAIN;
        l.r.y = '0;
        l.r.z = z;
        return l;
    endfunction

    logic [31:0] phase_u;
    logic [31:0] phase_v;
    cord_t       cd      [0:CORDIC_CELLS];
    logic        cd_v    [0:CORDIC_CELLS];
    logic        cd_r    [0:CORDIC_CELLS];

    assign phase_u = {s_axis_tdata[15:0], 16'h0000} & PHASE_MASK;
    assign phase_v = {s_axis_tdata[31:16], 16'h0000} & PHASE_MASK;

    always_comb
    begin
        cd[0].u = fold(phase_u);
        cd[0].v = fold(phase_v);
        cd[0].w = fold({phase_v[30:0], 1'b0});
    end

    assign cd_v[0]       = s_axis_tvalid;
    assign s_axis_tready = cd_r[0];

    for (genvar i = 0; i < CORDIC_CELLS; i++)
    begin : g_cordic
        cotp_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (5'(i)),
            .in_valid  (cd_v[i]),
            .in_ready  (cd_r[i]),
            .in_data   (cd[i]),
            .out_valid (cd_v[i+1]),
            .out_ready (cd_r[i+1]),
            .out_data  (cd[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Front stages: undo fold, c = a^2 cos2v, c^2, radicand
    // ------------------------------------------------------------------
    localparam int FA = 4;

    pt_t  fa_reg  [0:FA-1];
    pt_t  fa_next [0:FA-1];
    logic fa_v    [0:FA-1];
    logic fa_r    [0:FA-1];

    logic signed [64:0] prod_c;
    logic [32:0]        cmag;
    logic [65:0]        csq_full;
    logic signed [59:0] disc;

    logic sq1_in_ready;

    always_comb
    begin
        fa_next[0]     = fa_reg[0];
        fa_next[0].cu  = 32'(cd[CORDIC_CELLS].u.flip ? -cd[CORDIC_CELLS].u.r.x
                                                     :  cd[CORDIC_CELLS].u.r.x);
        fa_next[0].su  = 32'(cd[CORDIC_CELLS].u.flip ? -cd[CORDIC_CELLS].u.r.y
                                                     :  cd[CORDIC_CELLS].u.r.y);
        fa_next[0].cv  = 32'(cd[CORDIC_CELLS].v.flip ? -cd[CORDIC_CELLS].v.r.x
                                                     :  cd[CORDIC_CELLS].v.r.x);
        fa_next[0].sv  = 32'(cd[CORDIC_CELLS].v.flip ? -cd[CORDIC_CELLS].v.r.y
                                                     :  cd[CORDIC_CELLS].v.r.y);
        fa_next[0].c2v = 32'(cd[CORDIC_CELLS].w.flip ? -cd[CORDIC_CELLS].w.r.x
                                                     :  cd[CORDIC_CELLS].w.r.x);

        prod_c         = 65'($signed({1'b0, a2_reg})) * 65'(fa_reg[0].c2v);
        fa_next[1]     = fa_reg[0];
        fa_next[1].c   = 34'(prod_c >>> 30);

        cmag           = fa_reg[1].c[33] ? 33'(-fa_reg[1].c) : 33'(fa_reg[1].c);
        csq_full       = 66'(cmag) * 66'(cmag);
        fa_next[2]     = fa_reg[1];
        fa_next[2].csq = csq_full[65:8];

        // Negative first radicand: flag the point and run zeros through the root
        disc           = 60'(base_reg) + $signed({2'b00, fa_reg[2].csq});
        fa_next[3]      = fa_reg[2];
        fa_next[3].ok   = !disc[59];
        fa_next[3].rad  = disc[59] ? 60'd0 : 60'(disc);
        fa_next[3].root = '0;
        fa_next[3].rem  = '0;
    end

    always_comb
    begin
        for (int k = FA - 1; k >= 0; k--)
            fa_r[k] = !fa_v[k] || ((k == FA - 1) ? sq1_in_ready : fa_r[(k + 1) % FA]);
    end

    assign cd_r[CORDIC_CELLS] = fa_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < FA; k++)
                fa_v[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < FA; k++)
                if (fa_r[k])
                    fa_v[k] <= (k == 0) ? cd_v[CORDIC_CELLS] : fa_v[(k + FA - 1) % FA];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < FA; k++)
            if (fa_r[k] && ((k == 0) ? cd_v[CORDIC_CELLS] : fa_v[(k + FA - 1) % FA]))
                fa_reg[k] <= fa_next[k];
    end

    // ------------------------------------------------------------------
    // First square-root row
    // ------------------------------------------------------------------
    pt_t  s1   [0:SQRT1_CELLS];
    logic s1_v [0:SQRT1_CELLS];
    logic s1_r [0:SQRT1_CELLS];

    assign s1[0]        = fa_reg[FA-1];
    assign s1_v[0]      = fa_v[FA-1];
    assign sq1_in_ready = s1_r[0];

    for (genvar i = 0; i < SQRT1_CELLS; i++)
    begin : g_sqrt1
        cotp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s1_v[i]),
            .in_ready  (s1_r[i]),
            .in_data   (s1[i]),
            .out_valid (s1_v[i+1]),
            .out_ready (s1_r[i+1]),
            .out_data  (s1[i+1])
        );
    end

    // ------------------------------------------------------------------
    // m = c/16 + root, aligned so the second row sees m*16 in its top bits
    // ------------------------------------------------------------------
    pt_t                mid_reg;
    pt_t                mid_next;
    logic               mid_v;
    logic               mid_r;
    logic signed [34:0] m_val;

    always_comb
    begin
        m_val         = 35'(s1[SQRT1_CELLS].c >>> 4) + $signed({5'b0, s1[SQRT1_CELLS].root});
        mid_next      = s1[SQRT1_CELLS];
        mid_next.ok   = s1[SQRT1_CELLS].ok && !m_val[34];
        mid_next.rad  = mid_next.ok ? {m_val[31:0], 28'd0} : 60'd0;
        mid_next.root = '0;
        mid_next.rem  = '0;
    end

    logic s2_in_ready;

    assign mid_r                = !mid_v || s2_in_ready;
    assign s1_r[SQRT1_CELLS]    = mid_r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mid_v <= 1'b0;
        else if (mid_r)
            mid_v <= s1_v[SQRT1_CELLS];
    end

    always_ff @(posedge clk)
    begin
        if (mid_r && s1_v[SQRT1_CELLS])
            mid_reg <= mid_next;
    end

    // ------------------------------------------------------------------
    // Second square-root row: r = sqrt(m*16)
    // ------------------------------------------------------------------
    pt_t  s2   [0:SQRT2_CELLS];
    logic s2_v [0:SQRT2_CELLS];
    logic s2_r [0:SQRT2_CELLS];

    assign s2[0]       = mid_reg;
    assign s2_v[0]     = mid_v;
    assign s2_in_ready = s2_r[0];

    for (genvar i = 0; i < SQRT2_CELLS; i++)
    begin : g_sqrt2
        cotp_sqrt_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (s2_v[i]),
            .in_ready  (s2_r[i]),
            .in_data   (s2[i]),
            .out_valid (s2_v[i+1]),
            .out_ready (s2_r[i+1]),
            .out_data  (s2[i+1])
        );
    end

    // ------------------------------------------------------------------
    // Back stages: r*sin v, r*cos v; w and y; w*cos u, w*sin u; clamp
    // ------------------------------------------------------------------
    localparam int BK = 4;

    function automatic logic [18:0] sat_coord(input logic signed [22:0] v);
        logic [18:0] o;
        if (v > 23'sd262143)
            o = 19'h3FFFF;
        else if (v < -23'sd262144)
            o = 19'h40000;
        else
            o = v[18:0];
        return o;
    endfunction

    pt_t  bk_reg  [0:BK-1];
    pt_t  bk_next [0:BK-1];
    logic bk_v    [0:BK-1];
    logic bk_r    [0:BK-1];

    logic signed [50:0] prod_rs;
    logic signed [50:0] prod_rc;
    logic signed [52:0] prod_x;
    logic signed [52:0] prod_z;

    always_comb
    begin
        prod_rs        = 51'($signed({1'b0, s2[SQRT2_CELLS].root[17:0]}))
                         * 51'(s2[SQRT2_CELLS].sv);
        prod_rc        = 51'($signed({1'b0, s2[SQRT2_CELLS].root[17:0]}))
                         * 51'(s2[SQRT2_CELLS].cv);
        bk_next[0]     = s2[SQRT2_CELLS];
        bk_next[0].rsv = 20'(prod_rs >>> 30);
        bk_next[0].rcv = 20'(prod_rc >>> 30);

        bk_next[1]     = bk_reg[0];
        bk_next[1].w   = $signed({5'b0, major_radius_reg}) + 21'(bk_reg[0].rsv);
        bk_next[1].y   = sat_coord(23'(bk_reg[0].rcv));

        prod_x         = 53'(bk_reg[1].w) * 53'(bk_reg[1].cu);
        prod_z         = 53'(bk_reg[1].w) * 53'(bk_reg[1].su);
        bk_next[2]     = bk_reg[1];
        bk_next[2].px  = 23'(prod_x >>> 30);
        bk_next[2].pz  = 23'(prod_z >>> 30);

        // Invalid point: zero all three coordinates
        bk_next[3]     = bk_reg[2];
        bk_next[3].x   = bk_reg[2].ok ? sat_coord(bk_reg[2].px) : 19'd0;
        bk_next[3].y   = bk_reg[2].ok ? bk_reg[2].y : 19'd0;
        bk_next[3].z   = bk_reg[2].ok ? sat_coord(bk_reg[2].pz) : 19'd0;
    end

    always_comb
    begin
        for (int k = BK - 1; k >= 0; k--)
            bk_r[k] = !bk_v[k] || ((k == BK - 1) ? m_axis_tready : bk_r[(k + 1) % BK]);
    end

    assign s2_r[SQRT2_CELLS] = bk_r[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < BK; k++)
                bk_v[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < BK; k++)
                if (bk_r[k])
                    bk_v[k] <= (k == 0) ? s2_v[SQRT2_CELLS] : bk_v[(k + BK - 1) % BK];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < BK; k++)
            if (bk_r[k] && ((k == 0) ? s2_v[SQRT2_CELLS] : bk_v[(k + BK - 1) % BK]))
                bk_reg[k] <= bk_next[k];
    end

    // Output register is the last back stage
    assign m_axis_tvalid = bk_v[BK-1];
    assign m_axis_tdata  = {7'd0, bk_reg[BK-1].z, bk_reg[BK-1].y, bk_reg[BK-1].x};
    assign m_axis_tuser  = bk_reg[BK-1].ok;

endmodule

// ===== hdl/cotp_checker.sv =====
`timescale 1ns / 1ps

module cotp_checker
    import cotp_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata,
    input logic        m_axis_tuser
);

    logic [OUT_DEPTH_W-1:0] pending_reg;
    logic [OUT_DEPTH_W-1:0] pending_next;

    always_comb
    begin
        pending_next = pending_reg;
        if (s_axis_tvalid && s_axis_tready)
            pending_next = pending_next + OUT_DEPTH_W'(1);
        if (m_axis_tvalid && m_axis_tready)
            pending_next = pending_next - OUT_DEPTH_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pending_reg <= '0;
        else
            pending_reg <= pending_next;
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // No result without an item in flight
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> pending_reg != '0)
        else $error("result with no item in flight");

    // Invalid points carry zero coordinates
    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == 64'd0)
        else $error("invalid point with nonzero coordinates");

    // Padding bits stay clear
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[63:57] == 7'd0)
        else $error("padding bits set");

endmodule

bind cassini_oval_torus_point cotp_checker u_cotp_checker (.*);

// ===== tb/cassini_oval_torus_point_tb.sv =====
`timescale 1ns / 1ps

module cassini_oval_torus_point_tb;
    import cotp_pkg::*;

    // Expected point: three saturated coordinates and the validity flag
    typedef struct {
        logic [18:0] x;
        logic [18:0] y;
        logic [18:0] z;
        logic        ok;
    } torus_point_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata;   // angle_u[15:0], angle_v[31:16]
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [63:0] m_axis_tdata;   // coord_x[18:0], coord_y[37:19], coord_z[56:38], zero
    logic        m_axis_tuser;   // point_valid[0]
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;

    // Local copy of the three registers used for prediction
    longint unsigned radius_reg;
    longint unsigned a_reg;
    longint unsigned b_reg;

    logic [31:0]  angle_queue[$];   // items waiting to be sent
    torus_point_t point_queue[$];   // points waiting to come out
    bit           failed;
    int           burst_left;
    int           gap_left;
    int           rx_cycle;

    // atan(2^-i) in units of 2^-32 turn
    const logic [31:0] arc_table[30] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
        32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
        32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051, 32'h00000029,
        32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000003, 32'h00000001
    };

    cassini_oval_torus_point uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Floor square root, one result bit per pass
    function automatic longint unsigned floor_sqrt(input longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Cosine and sine of a 32-bit phase in Q1.30, folded into +-1/4 turn
    function automatic void rotate(input logic [31:0] phase,
                                   output longint cs, output longint sn);
        longint z;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        z    = phase[31] ? longint'({32'd0, phase}) - 64'sd4294967296
                         : longint'({32'd0, phase});
        x    = 652032874;
        y    = 0;
        flip = 1'b0;
        if (z > 64'sd1073741824)
        begin
            z    = z - 64'sd2147483648;
            flip = 1'b1;
        end
        else if (z < -64'sd1073741824)
        begin
            z    = z + 64'sd2147483648;
            flip = 1'b1;
        end
        for (int i = 0; i < CORDIC_CELLS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - longint'({32'd0, arc_table[i]});
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + longint'({32'd0, arc_table[i]});
            end
        end
        cs = flip ? -x : x;
        sn = flip ? -y : y;
    endfunction

    function automatic logic [18:0] clamp_coord(input longint v);
        if (v > 262143)
            v = 262143;
        if (v < -262144)
            v = -262144;
        return v[18:0];
    endfunction

    // Work out the torus point for one angle pair under the current registers
    function automatic torus_point_t torus_point(input logic [31:0] angles);
        torus_point_t    p;
        logic [31:0]     pu;
        logic [31:0]     pv;
        longint          cu, su, cv, sv, c2v, s2v;
        longint unsigned a2, b2, a4, b4, cmag;
        longint          c, disc, m, r, w;
        pu = {angles[15:0], 16'd0} & PHASE_MASK;
        pv = {angles[31:16], 16'd0} & PHASE_MASK;
        rotate(pu, cu, su);
        rotate(pv, cv, sv);
        rotate(pv * 32'd2, c2v, s2v);
        a2   = a_reg * a_reg;
        b2   = b_reg * b_reg;
        a4   = a2 * a2;
        b4   = b2 * b2;
        c    = (longint'(a2) * c2v) >>> 30;
        cmag = (c < 0) ? longint'(-c) : longint'(c);
        disc = longint'(b4 >> 8) - longint'(a4 >> 8) + longint'((cmag * cmag) >> 8);
        m    = -1;
        if (disc >= 0)
            m = (c >>> 4) + longint'(floor_sqrt(disc));
        if (disc < 0 || m < 0)
        begin
            p.x  = '0;
            p.y  = '0;
            p.z  = '0;
            p.ok = 1'b0;
            return p;
        end
        r    = longint'(floor_sqrt(longint'(m) << 4));
        w    = longint'(radius_reg) + ((r * sv) >>> 30);
        p.x  = clamp_coord((w * cu) >>> 30);
        p.y  = clamp_coord((r * cv) >>> 30);
        p.z  = clamp_coord((w * su) >>> 30);
        p.ok = 1'b1;
        return p;
    endfunction

    // Sender: bursts of random length with random gaps, fed from angle_queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                point_queue.push_back(torus_point(s_axis_tdata));
            // Hold the item while the block stalls it
            if (!(s_axis_tvalid && !s_axis_tready))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    s_axis_tvalid <= 1'b0;
                end
                else if (angle_queue.size() > 0)
                begin
                    s_axis_tdata  <= angle_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    if (burst_left == 0)
                    begin
                        burst_left = $urandom_range(1, 40);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                    end
                    else
                        burst_left--;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: always ready, random, or mostly stalled, taking the three modes in turn
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            rx_cycle = 0;
        end
        else
        begin
            rx_cycle++;
            case ((rx_cycle >> 7) % 3)
                0:       m_axis_tready <= 1'b1;
                1:       m_axis_tready <= $urandom_range(0, 1);
                default: m_axis_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Compare each accepted point with the oldest expectation
    always @(posedge clk)
    begin
        torus_point_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (point_queue.size() == 0)
            begin
                $error("point with no expectation waiting");
                failed = 1'b1;
            end
            else
            begin
                want = point_queue.pop_front();
                if (m_axis_tdata[18:0] !== want.x)
                begin
                    $error("coord_x expected %0d got %0d",
                           $signed(want.x), $signed(m_axis_tdata[18:0]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[37:19] !== want.y)
                begin
                    $error("coord_y expected %0d got %0d",
                           $signed(want.y), $signed(m_axis_tdata[37:19]));
                    failed = 1'b1;
                end
                if (m_axis_tdata[56:38] !== want.z)
                begin
                    $error("coord_z expected %0d got %0d",
                           $signed(want.z), $signed(m_axis_tdata[56:38]));
                    failed = 1'b1;
                end
                if (m_axis_tuser !== want.ok)
                begin
                    $error("point_valid expected %0b got %0b", want.ok, m_axis_tuser);
                    failed = 1'b1;
                end
            end
        end
    end

    // Write one register; track it locally once the write is taken, then idle with
    // valid low so back-to-back writes never drive valid twice in a step
    task automatic write_reg(input reg_index_t idx, input logic [15:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_MAJOR_RADIUS: radius_reg = value;
            REG_OVAL_A:       a_reg      = value;
            REG_OVAL_B:       b_reg      = value;
            default:          ;
        endcase
        @(posedge clk);
    endtask

    task automatic load_regs(input logic [15:0] rr, input logic [15:0] aa,
                             input logic [15:0] bb);
        write_reg(REG_MAJOR_RADIUS, rr);
        write_reg(REG_OVAL_A, aa);
        write_reg(REG_OVAL_B, bb);
    endtask

    // Wait until every item is sent and every point has come out, then let
    // the pipeline settle for longer than its latency
    task automatic drain();
        do
            @(posedge clk);
        while (angle_queue.size() != 0 || s_axis_tvalid || point_queue.size() != 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic send(input logic [15:0] u, input logic [15:0] v);
        angle_queue.push_back({v, u});
    endtask

    initial
    begin
        logic [15:0] ra, rb;
        failed        = 1'b0;
        radius_reg    = 4096;
        a_reg         = 4096;
        b_reg         = 4096;
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_MAJOR_RADIUS;
        cfg_data      = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values: zero and full-scale angles, quarter and eighth turns
        send(16'h0000, 16'h0000);
        send(16'hFFFF, 16'hFFFF);
        send(16'h4000, 16'h0000);
        send(16'h8000, 16'h4000);
        send(16'hC000, 16'h8000);
        send(16'h0000, 16'hC000);
        send(16'h2000, 16'h2000);
        send(16'h1234, 16'hE000);
        drain();

        // a above b: eighth turn gives a negative first radicand,
        // quarter turn a negative m; index 3 must be ignored
        load_regs(16'd4096, 16'd8192, 16'd4096);
        write_reg(REG_NONE, 16'hFFFF);
        send(16'h0000, 16'h2000);
        send(16'h5555, 16'h4000);
        send(16'hAAAA, 16'h0000);
        send(16'hFFFF, 16'h6000);
        drain();

        // Largest register values: radius, oval_a and oval_b all at 16'hFFFF
        load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send(16'h0000, 16'h0000);
        send(16'h4000, 16'h4000);
        send(16'h8000, 16'hC000);
        send(16'hC000, 16'h8000);
        send(16'h6000, 16'h3000);
        drain();

        // All zero
        load_regs(16'h0000, 16'h0000, 16'h0000);
        send(16'h1111, 16'h2222);
        send(16'hFFFF, 16'h0000);
        drain();

        // Random phases: mostly b near a so most points are valid
        for (int phase_n = 0; phase_n < 8; phase_n++)
        begin
            ra = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(1024, 16384));
            rb = $urandom_range(0, 3) == 0 ? 16'($urandom) : ra + 16'($urandom_range(0, 2048));
            load_regs(16'($urandom), ra, rb);
            for (int k = 0; k < 250; k++)
                send(16'($urandom), 16'($urandom));
            drain();
        end

        if (point_queue.size() != 0)
            failed = 1'b1;
        if (!failed)
            $display("cassini_oval_torus_point verification clean");
        else
            $display("cassini_oval_torus_point verification failed");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("cassini_oval_torus_point verification failed");
        $finish;
    end

endmodule
